[design/nrw_pkg.sv]
`timescale 1ns / 1ps
// nrw_pkg: shared types and codes for the nonce replay window
// no dependencies

package nrw_pkg;

  localparam int STATUS_W = 3;
  localparam int DROP_W   = 6;
  localparam int CAP_W    = 6;
  localparam int TIME_W   = 64;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MALFORMED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EXPIRED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_EXPIRY = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REPLAY    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;
  localparam logic [STATUS_W-1:0] ST_BEYOND    = 3'd6;

  localparam logic FUNC_ADMIT = 1'b0;
  localparam logic FUNC_SWEEP = 1'b1;

  localparam logic REG_HORIZON  = 1'b0;
  localparam logic REG_CAPACITY = 1'b1;

  localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SWEEP  = 3'b010,
    S_FINISH = 3'b100
  } state_t;

endpackage

[design/nrw_ram.sv]
`timescale 1ns / 1ps
// nrw_ram: generic single write port ram with registered read
// no dependencies

module nrw_ram #(
  parameter int WIDTH = 192,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/nonce_replay_window.sv]
`timescale 1ns / 1ps
// nonce_replay_window: replay table of nonces with expiry, swept on every request
// depends on nrw_pkg and nrw_ram
//
// Usage:
//   in_*  : one request beat (admit or sweep only), valid/ready.
//   out_* : one result beat per request (status, dropped count), valid/ready.
//   cfg_* : always ready register writes, index 0 horizon, index 1 capacity in use;
//           the user must write them only while the block is idle; not enforced.
// Each request walks the stored entries once through a single ram port
// pair: one entry read, compared against now and the nonce, and copied down
// if it survives, per cycle. An accepted request goes from idle through the
// sweep state, which walks the N live entries (0..DEPTH), to the finish
// state that raises out_valid. When the count is above the capacity no sweep
// runs; idle goes straight to finish. in_ready is high only between requests.
// A finished result sits in the output register; the next request may be
// accepted and swept meanwhile, and waits at its last step if the result
// is still not taken. Reset empties the table (count only, no clear pass),
// sets horizon to 0 and capacity to 32.

module nonce_replay_window #(
  parameter int DEPTH       = 32,
  parameter int NONCE_BYTES = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,

  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_func,
  input  logic [63:0]                    in_nonce_lo,
  input  logic [63:0]                    in_nonce_hi,
  input  logic [nrw_pkg::TIME_W-1:0]     in_expiry_time,
  input  logic                           in_expiry_optional,
  input  logic [nrw_pkg::TIME_W-1:0]     in_time_now,

  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [nrw_pkg::STATUS_W-1:0]   out_status,
  output logic [nrw_pkg::DROP_W-1:0]     out_dropped_count,

  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [63:0]                    cfg_data
);

  import nrw_pkg::*;

  localparam int NW = 8 * NONCE_BYTES;
  localparam int EW = NW + TIME_W;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > CAP_W) ? CW : CAP_W;

  // configuration
  logic [TIME_W-1:0] horizon_r;
  logic [CAP_W-1:0]  cap_r;

  // sequencer and request
  state_t            state_r, state_nxt;
  logic              func_r;
  logic [NW-1:0]     nonce_r;
  logic [TIME_W-1:0] exp_r;
  logic [TIME_W-1:0] now_r;
  logic [STATUS_W-1:0] fresh_r;
  logic              skip_r, skip_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     rd_r, rd_nxt;
  logic              pend_r, pend_nxt;
  logic [CW-1:0]     kept_r, kept_nxt;
  logic              hit_r, hit_nxt;

  // result
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [DROP_W-1:0]   out_dropped_r, out_dropped_nxt;

  // ram
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] ram_rdata;

  logic [127:0]        in_nonce_full;
  logic [NW-1:0]       in_nonce;
  logic [TIME_W:0]     edge_sum;
  logic [TIME_W-1:0]   edge_time;
  logic [STATUS_W-1:0] in_fresh;
  logic [XW-1:0]       cap_eff;
  logic [XW-1:0]       count_x;
  logic [XW-1:0]       kept_x;
  logic [XW-1:0]       drop_x;
  logic                in_acc;
  logic                finish_go;
  logic                survive;
  logic                key_match;
  logic                want_store;
  logic                full;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_dropped_count = out_dropped_r;

  assign in_nonce_full = {in_nonce_hi, in_nonce_lo};
  assign in_nonce      = in_nonce_full[NW-1:0];

  // freshness of the incoming item, saturating horizon edge
  assign edge_sum  = {1'b0, in_time_now} + {1'b0, horizon_r};
  assign edge_time = edge_sum[TIME_W] ? {TIME_W{1'b1}} : edge_sum[TIME_W-1:0];

  always_comb begin
    if (horizon_r == '0) begin
      in_fresh = ST_MALFORMED;
    end else if (in_expiry_time == '0) begin
      in_fresh = in_expiry_optional ? ST_OK : ST_NO_EXPIRY;
    end else if (in_expiry_time <= in_time_now) begin
      in_fresh = ST_EXPIRED;
    end else if (in_expiry_time > edge_time) begin
      in_fresh = ST_BEYOND;
    end else begin
      in_fresh = ST_OK;
    end
  end

  assign cap_eff = (XW'(cap_r) > XW'(DEPTH)) ? XW'(DEPTH) : XW'(cap_r);
  assign count_x = XW'(count_r);
  assign kept_x  = XW'(kept_r);
  assign drop_x  = count_x - kept_x;

  // the shared compare unit: one stored entry per cycle
  assign survive   = ram_rdata[EW-1:NW] > now_r;
  assign key_match = ram_rdata[NW-1:0] == nonce_r;

  assign want_store = (func_r == FUNC_ADMIT) && (fresh_r == ST_OK) && (exp_r != '0);
  assign full       = kept_x >= cap_eff;
  assign finish_go  = (state_r == S_FINISH) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt       = state_r;
    skip_nxt        = skip_r;
    count_nxt       = count_r;
    rd_nxt          = rd_r;
    pend_nxt        = pend_r;
    kept_nxt        = kept_r;
    hit_nxt         = hit_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_status_nxt  = out_status_r;
    out_dropped_nxt = out_dropped_r;
    ram_we          = 1'b0;
    ram_waddr       = kept_r[AW-1:0];
    ram_wdata       = ram_rdata;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          rd_nxt   = '0;
          pend_nxt = 1'b0;
          kept_nxt = '0;
          hit_nxt  = 1'b0;
          if (count_x > cap_eff) begin
            skip_nxt  = 1'b1;
            state_nxt = S_FINISH;
          end else begin
            skip_nxt  = 1'b0;
            state_nxt = S_SWEEP;
          end
        end
      end
      S_SWEEP: begin
        if (pend_r && survive) begin
          ram_we   = 1'b1;
          kept_nxt = kept_r + CW'(1);
          if (key_match) begin
            hit_nxt = 1'b1;
          end
        end
        if (rd_r == count_r) begin
          pend_nxt  = 1'b0;
          state_nxt = S_FINISH;
        end else begin
          pend_nxt = 1'b1;
          rd_nxt   = rd_r + CW'(1);
        end
      end
      S_FINISH: begin
        if (finish_go) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (skip_r) begin
            out_status_nxt  = (func_r == FUNC_SWEEP) ? ST_OK : ST_MALFORMED;
            out_dropped_nxt = '0;
          end else begin
            out_dropped_nxt = drop_x[DROP_W-1:0];
            count_nxt       = kept_r;
            if (func_r == FUNC_SWEEP) begin
              out_status_nxt = ST_OK;
            end else if (!want_store) begin
              out_status_nxt = fresh_r;
            end else if (hit_r) begin
              out_status_nxt = ST_REPLAY;
            end else if (full) begin
              out_status_nxt = ST_FULL;
            end else begin
              out_status_nxt = ST_OK;
              ram_we         = 1'b1;
              ram_wdata      = {exp_r, nonce_r};
              count_nxt      = kept_r + CW'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  nrw_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      horizon_r   <= '0;
      cap_r       <= CAP_RESET;
      skip_r      <= 1'b0;
      rd_r        <= '0;
      pend_r      <= 1'b0;
      kept_r      <= '0;
      hit_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      skip_r      <= skip_nxt;
      rd_r        <= rd_nxt;
      pend_r      <= pend_nxt;
      kept_r      <= kept_nxt;
      hit_r       <= hit_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_HORIZON) begin
          horizon_r <= cfg_data;
        end else begin
          cap_r <= cfg_data[CAP_W-1:0];
        end
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r  <= in_func;
      nonce_r <= in_nonce;
      exp_r   <= in_expiry_time;
      now_r   <= in_time_now;
      fresh_r <= in_fresh;
    end
    out_status_r  <= out_status_nxt;
    out_dropped_r <= out_dropped_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    XW'(count_r) <= XW'(DEPTH))
    else $error("entry count beyond table depth");

  a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP) |-> (kept_r <= rd_r) && (rd_r <= count_r))
    else $error("compaction write overtook the read pointer");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FINISH))
    else $error("result raised outside the finishing step");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready again straight after an accepted beat");

endmodule
